### hw/rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_READ_FWD   = 2'd2,
        ACT_READ_BWD   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

endpackage

### hw/rtl/dq_mem.sv
// word storage: one write port and one registered read port with enable
module dq_mem #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic signed [dq_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic signed [dq_pkg::WORD_W-1:0]  o_rd_data
);

    logic signed [dq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [dq_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/deque_with_bidirectional_readout_unit.sv
// double-ended queue top level: control sequencer, pointers and output register
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  in      | i_valid / o_stall     | i_action, i_value
//  out     | o_valid / i_stall     | o_word, o_last, o_status
//
// a push or an empty readout yields one result.
// a readout of n words yields one word per cycle while the output is not
// stalled, through the single read port of the storage memory.
// reset clears the front pointer and the word count; storage is not cleared.
// a stall on the output freezes the readout walk and holds the result.
// no request is taken while a readout is in progress.
module deque_with_bidirectional_readout_unit #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_action,
    input  logic signed [dq_pkg::WORD_W-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [dq_pkg::WORD_W-1:0]  o_word,
    output logic                              o_last,
    output logic [1:0]                        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [AW:0]   WRAP_SUM   = (AW + 1)'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_left, n_left;
    logic             r_bwd, n_bwd;
    logic             r_out_valid, n_out_valid;
    logic signed [dq_pkg::WORD_W-1:0] r_out_word, n_out_word;
    logic             r_out_last, n_out_last;
    dq_pkg::t_status  r_out_status, n_out_status;

    logic             out_free;
    logic             in_acc;
    logic             is_full;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic signed [dq_pkg::WORD_W-1:0] mem_rd_data;

    logic [AW-1:0]    front_dec;
    logic [AW:0]      back_sum;
    logic [AW-1:0]    back_slot;
    logic [AW:0]      tail_sum;
    logic [AW-1:0]    tail_slot;
    logic [CW-1:0]    count_m1;
    logic [AW-1:0]    step_slot;

    // modular slot arithmetic: sums stay below twice the depth
    always_comb begin
        count_m1  = r_count - 1'b1;
        front_dec = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
        back_sum  = {1'b0, r_front} + {1'b0, r_count[AW-1:0]};
        back_slot = (back_sum >= WRAP_SUM) ? AW'(back_sum - WRAP_SUM) : back_sum[AW-1:0];
        tail_sum  = {1'b0, r_front} + {1'b0, count_m1[AW-1:0]};
        tail_slot = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : tail_sum[AW-1:0];
        if (r_bwd) begin
            step_slot = (r_slot == '0) ? LAST_SLOT : r_slot - 1'b1;
        end else begin
            step_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign is_full  = (r_count >= FULL_COUNT);
    assign in_acc   = i_valid && (r_state == S_IDLE) && out_free;
    assign o_stall  = !((r_state == S_IDLE) && out_free);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_slot       = r_slot;
        n_left       = r_left;
        n_bwd        = r_bwd;
        n_out_valid  = r_out_valid && i_stall;
        n_out_word   = r_out_word;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = back_slot;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = step_slot;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = dq_pkg::STAT_OK;
                    unique case (dq_pkg::t_action'(i_action))
                        dq_pkg::ACT_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out_status = dq_pkg::STAT_FULL;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_dec;
                                n_front     = front_dec;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        dq_pkg::ACT_PUSH_BACK: begin
                            if (is_full) begin
                                n_out_status = dq_pkg::STAT_FULL;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = back_slot;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        dq_pkg::ACT_READ_FWD, dq_pkg::ACT_READ_BWD: begin
                            if (r_count == '0) begin
                                n_out_status = dq_pkg::STAT_EMPTY;
                            end else begin
                                // first word comes out after the read latency
                                n_out_valid = 1'b0;
                                n_bwd       = (i_action == dq_pkg::ACT_READ_BWD);
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = (i_action == dq_pkg::ACT_READ_BWD) ?
                                              tail_slot : r_front;
                                n_slot      = mem_rd_addr;
                                n_left      = r_count;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = mem_rd_data;
                    n_out_last   = (r_left == CW'(1));
                    n_out_status = dq_pkg::STAT_OK;
                    n_left       = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = step_slot;
                        n_slot      = step_slot;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_slot       <= n_slot;
        r_bwd        <= n_bwd;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // writes only happen in idle, so a read never overlaps a write in flight
    dq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_valid  = r_out_valid;
    assign o_word   = r_out_word;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("word count above depth");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !mem_wr_en)
        else $error("storage written during readout");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != '0) && (r_left <= r_count))
        else $error("readout walk count out of range");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_action[1]) |=> (r_out_valid && r_out_last &&
        (r_out_status == dq_pkg::STAT_OK || r_out_status == dq_pkg::STAT_FULL)))
        else $error("push request gave no status result");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action[1] && (r_count == '0)) |=>
        (r_out_valid && r_out_last && r_out_status == dq_pkg::STAT_EMPTY &&
         r_state == S_IDLE))
        else $error("empty readout not flagged");

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the double-ended queue with bidirectional readout
module testbench;
    import dq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int N_RANDOM   = 480;
    localparam int PHASE_LEN  = 60;
    localparam int TAIL_WAIT  = 2 * DEPTH + 8;

    typedef struct {
        t_action                   action;
        logic signed [WORD_W-1:0]  value;
        bit                        drain;
        int unsigned               phase;
    } request_t;

    typedef struct {
        logic signed [WORD_W-1:0]  word;
        logic                      last;
        t_status                   status;
    } result_t;

    // idle and stall chances per phase: none, sender, receiver, both
    int unsigned tx_idle_pct [4] = '{0, 70, 0, 25};
    int unsigned rx_stall_tab[4] = '{0, 0, 70, 25};

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        i_valid  = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_action = ACT_PUSH_FRONT;
    logic signed [WORD_W-1:0]    i_value  = '0;
    logic                        o_valid;
    logic                        i_stall  = 1'b0;
    logic signed [WORD_W-1:0]    o_word;
    logic                        o_last;
    logic [1:0]                  o_status;

    request_t     pending_requests[$];
    result_t      expected_results[$];
    int unsigned  rx_stall_pct = 0;

    // shadow deque state
    logic signed [WORD_W-1:0]  shadow_words[DEPTH];
    int unsigned               shadow_front = 0;
    int unsigned               shadow_count = 0;

    int unsigned  fail_cnt     = 0;
    int unsigned  results_seen = 0;
    int unsigned  n_pushed     = 0;
    int unsigned  n_refused    = 0;
    int unsigned  n_readouts   = 0;
    int unsigned  n_empty_read = 0;
    int unsigned  plan_count   = 0;

    deque_with_bidirectional_readout_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_word   (o_word),
        .o_last   (o_last),
        .o_status (o_status)
    );

    always #4 i_clk = ~i_clk;

    task automatic predict_deque_outputs(input t_action act,
                                         input logic signed [WORD_W-1:0] val);
        int unsigned k;
        int unsigned offset;
        result_t     r;
        r.word   = '0;
        r.last   = 1'b1;
        r.status = STAT_OK;
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
            if (shadow_count >= DEPTH) begin
                r.status = STAT_FULL;
                n_refused++;
            end else begin
                if (act == ACT_PUSH_FRONT) begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_words[shadow_front] = val;
                end else begin
                    shadow_words[(shadow_front + shadow_count) % DEPTH] = val;
                end
                shadow_count++;
                n_pushed++;
            end
            expected_results.push_back(r);
        end else if (shadow_count == 0) begin
            r.status = STAT_EMPTY;
            n_empty_read++;
            expected_results.push_back(r);
        end else begin
            n_readouts++;
            for (k = 0; k < shadow_count; k++) begin
                offset = (act == ACT_READ_FWD) ? k : shadow_count - 1 - k;
                r.word = shadow_words[(shadow_front + offset) % DEPTH];
                r.last = (k + 1 == shadow_count);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic add_request(input t_action act, input logic [WORD_W-1:0] val,
                               input bit drain, input int unsigned phase);
        request_t q;
        q.action = act;
        q.value  = val;
        q.drain  = drain;
        q.phase  = phase;
        pending_requests.push_back(q);
        if ((act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && plan_count < DEPTH)
            plan_count++;
    endtask

    // driver: valid held with a frozen payload until taken
    always @(posedge i_clk) begin : drive_requests
        bit can_send;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predict_deque_outputs(t_action'(i_action), i_value);
            if (!i_valid || !o_stall) begin
                can_send = pending_requests.size() != 0;
                // a drain request waits until every result is back
                if (can_send && pending_requests[0].drain && expected_results.size() != 0)
                    can_send = 1'b0;
                if (can_send &&
                    $urandom_range(99) >= tx_idle_pct[pending_requests[0].phase]) begin
                    i_valid      <= 1'b1;
                    i_action     <= pending_requests[0].action;
                    i_value      <= pending_requests[0].value;
                    rx_stall_pct <= rx_stall_tab[pending_requests[0].phase];
                    void'(pending_requests.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        result_t exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %0d last %0d status %0d",
                             $time, o_word, o_last, o_status);
                    fail_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_word !== exp_r.word) begin
                        $display("%0t: word mismatch expected %0d actual %0d",
                                 $time, exp_r.word, o_word);
                        fail_cnt++;
                    end
                    if (o_last !== exp_r.last) begin
                        $display("%0t: last mismatch expected %0d actual %0d",
                                 $time, exp_r.last, o_last);
                        fail_cnt++;
                    end
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_r.status, o_status);
                        fail_cnt++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned phase;
        bit          drain;
        t_action     act;

        // empty readouts, single-word readouts, extreme words, front wrap
        add_request(ACT_READ_FWD,   32'hFFFF_FFFF, 1'b0, 0);
        add_request(ACT_READ_BWD,   $urandom,      1'b0, 0);
        add_request(ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, 0);
        add_request(ACT_READ_FWD,   $urandom,      1'b0, 0);
        add_request(ACT_READ_BWD,   32'h0000_0000, 1'b0, 0);
        add_request(ACT_PUSH_FRONT, 32'h8000_0000, 1'b0, 0);
        add_request(ACT_READ_FWD,   $urandom,      1'b0, 0);
        add_request(ACT_READ_BWD,   $urandom,      1'b0, 0);
        add_request(ACT_PUSH_FRONT, 32'h0000_0000, 1'b0, 0);
        add_request(ACT_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, 0);
        add_request(ACT_PUSH_BACK,  32'h5555_5555, 1'b0, 0);
        add_request(ACT_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, 0);
        add_request(ACT_PUSH_FRONT, 32'h0000_0001, 1'b0, 0);
        add_request(ACT_READ_FWD,   $urandom,      1'b0, 0);
        add_request(ACT_READ_BWD,   $urandom,      1'b0, 0);

        // the queue only grows, so pushes are spread out until it fills,
        // after which refused pushes and full-length readouts follow
        for (i = 0; i < N_RANDOM; i++) begin
            phase = (i / PHASE_LEN) % 4;
            drain = (i % PHASE_LEN == 0);
            if ($urandom_range(99) < ((plan_count < DEPTH) ? 16 : 30))
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_READ_BWD : ACT_READ_FWD;
            add_request(act, $urandom, drain, phase);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            fail_cnt++;
        end
        $display("covered %0d pushes stored, %0d refused when full, %0d readouts, %0d empty",
                 n_pushed, n_refused, n_readouts, n_empty_read);
        $display("%0d results checked, %0d mismatches", results_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("deque_with_bidirectional_readout_unit verification clean");
        end else begin
            $display("deque_with_bidirectional_readout_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("deque_with_bidirectional_readout_unit verification failed");
        $finish;
    end

endmodule
